>>> src/assert_macros.svh
// Assertion macros shared by the solver modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> src/ctds_pkg.sv
// Package for the complex tridiagonal solver: types and constants.
package ctds_pkg;
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_NUM,
        ST_DEN,
        ST_DIVY,
        ST_DIVG,
        ST_STORE,
        ST_BRD,
        ST_BWAIT,
        ST_BMUL,
        ST_BEMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic prod_u;
        logic prod_b;
        logic num_y;
        logic num_g;
        logic den;
        logic div_start;
        logic div_sel_im;
        logic cap_yr;
        logic cap_yi;
        logic cap_gr;
        logic cap_gi;
        logic store;
        logic brd;
        logic bmul;
        logic bemit;
        logic run_clear;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic first_row;
        logic full;
        logic last;
        logic singular_now;
        logic back_first;
        logic back_zero;
    } stat_t;

    localparam int unsigned Word = 32;
endpackage

>>> src/ctds_div.sv
// Iterative radix-2 divider: (m << frac) / d, truncated, signed and saturated.
module ctds_div #(
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [63:0]        m,
    input  logic               neg,
    input  logic [63:0]        d,
    output logic               done,
    output logic signed [31:0] q
);
    import ctds_pkg::*;
    localparam int Steps = 64;
    logic [64:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next, q_reg, q_next;
    logic [63:0] d_reg;
    logic        neg_reg, sat_reg, busy_reg, busy_next, done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] hi;
    logic [64:0] sh;

    assign hi = m >> (64 - FRAC_BITS);
    assign sh = {rem_reg[63:0], lo_reg[63]};

    always_comb
    begin
        rem_next = rem_reg;
        lo_next = lo_reg;
        q_next = q_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = {1'b0, hi};
            lo_next = m << FRAC_BITS;
            q_next = '0;
            busy_next = 1'b1;
            cnt_next = '0;
        end
        else if (busy_reg)
        begin
            lo_next = lo_reg << 1;
            if (sh >= {1'b0, d_reg})
            begin
                rem_next = sh - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = sh;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(Steps - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg <= lo_next;
        q_reg <= q_next;
        if (start)
        begin
            d_reg <= d;
            neg_reg <= neg;
            sat_reg <= (hi >= d);
        end
    end

    assign done = done_reg;
    always_comb
    begin
        if (sat_reg || (q_reg > 64'h7FFFFFFF && !(neg_reg && q_reg == 64'h80000000)))
            q = neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
        else if (neg_reg)
            q = Word'(-q_reg[31:0]);
        else
            q = q_reg[31:0];
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_no_restart, clk, rst_n, busy_reg, !start)
    `ASSERT_NEXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `ASSERT_NEXT(a_done_end, clk, rst_n, done_reg, !busy_reg)
endmodule

>>> src/ctds_datapath.sv
// Datapath: row registers, complex multiply-subtract, pivot, stores and divider.
module ctds_datapath #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 24
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctds_pkg::cmd_t      cmd,
    output ctds_pkg::stat_t     stat,
    input  logic signed [31:0]  sub_re,
    input  logic signed [31:0]  sub_im,
    input  logic signed [31:0]  diag_re,
    input  logic signed [31:0]  diag_im,
    input  logic signed [31:0]  super_re,
    input  logic signed [31:0]  super_im,
    input  logic signed [31:0]  rhs_re,
    input  logic signed [31:0]  rhs_im,
    input  logic                last_row,
    output logic signed [31:0]  sol_re,
    output logic signed [31:0]  sol_im,
    output logic [5:0]          row_index,
    output logic                singular,
    output logic                too_long,
    output logic                end_of_run
);
    import ctds_pkg::*;
    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    logic [63:0] gamma_mem [MAX_ROWS];
    logic [63:0] part_mem  [MAX_ROWS];

    logic signed [31:0] sr_reg, si_reg, dr_reg, di_reg, cr_reg, ci_reg, rr_reg, ri_reg;
    logic last_reg;
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] bidx_reg;
    logic sing_reg, ovf_reg;
    logic signed [31:0] pr_reg, pi_reg, nr_reg, ni_reg;
    logic signed [31:0] yr_reg, yi_reg, gr_reg, gi_reg, xr_reg, xi_reg;
    logic [63:0] g_rd_reg, u_rd_reg;
    logic signed [63:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic [63:0] den_reg;
    logic [63:0] m_reg;
    logic mneg_reg;

    // Multiplier operands: a*y with a = sub (forward) or gamma (back).
    logic signed [31:0] ar, ai, yr_op, yi_op, xr_op, xi_op;
    logic signed [63:0] d_ar, d_ai;

    function automatic logic signed [39:0] mulq(input logic signed [63:0] p);
        logic signed [63:0] t;
        t = p >>> FRAC_BITS;
        return 40'(t);
    endfunction

    function automatic logic signed [31:0] sat(input logic signed [41:0] v);
        if (v > 42'sh7FFFFFFF) return 32'sh7FFFFFFF;
        if (v < -42'sh80000000) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] umag(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

    // Products are registered ahead of the subtract that uses them.
    always_comb
    begin
        ar = sr_reg;
        ai = si_reg;
        yr_op = g_rd_reg[31:0];
        yi_op = g_rd_reg[63:32];
        if (cmd.prod_b)
        begin
            ar = g_rd_reg[31:0];
            ai = g_rd_reg[63:32];
            yr_op = xr_reg;
            yi_op = xi_reg;
        end
        else if (cmd.prod_u)
        begin
            yr_op = u_rd_reg[31:0];
            yi_op = u_rd_reg[63:32];
        end
        if (cmd.bmul)
        begin
            xr_op = u_rd_reg[31:0];
            xi_op = u_rd_reg[63:32];
        end
        else if (cmd.mul2)
        begin
            xr_op = rr_reg;
            xi_op = ri_reg;
        end
        else
        begin
            xr_op = dr_reg;
            xi_op = di_reg;
        end
    end

    // cmsub result from registered products of the previous cycle.
    logic signed [31:0] zr, zi;
    assign zr = sat(42'(xr_op) - (42'(mulq(p0_reg)) - 42'(mulq(p1_reg))));
    assign zi = sat(42'(xi_op) - (42'(mulq(p2_reg)) + 42'(mulq(p3_reg))));
    assign d_ar = 64'(ar);
    assign d_ai = 64'(ai);

    // Numerator term magnitude: n*conj(p); re = nr*pr + ni*pi, im = ni*pr - nr*pi.
    logic signed [31:0] n_r, n_i;
    assign n_r = cmd.num_g ? cr_reg : nr_reg;
    assign n_i = cmd.num_g ? ci_reg : ni_reg;

    logic [63:0] m1, m2;
    logic n1, n2;
    always_comb
    begin
        if (!cmd.div_sel_im)
        begin
            m1 = 64'(umag(n_r)) * 64'(umag(pr_reg));
            m2 = 64'(umag(n_i)) * 64'(umag(pi_reg));
            n1 = (n_r[31] != pr_reg[31]) && m1 != 0;
            n2 = (n_i[31] != pi_reg[31]) && m2 != 0;
        end
        else
        begin
            m1 = 64'(umag(n_i)) * 64'(umag(pr_reg));
            m2 = 64'(umag(n_r)) * 64'(umag(pi_reg));
            n1 = (n_i[31] != pr_reg[31]) && m1 != 0;
            n2 = (n_r[31] == pi_reg[31]) && m2 != 0;
        end
    end

    logic div_done;
    logic signed [31:0] div_q;
    ctds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
        .m(m_reg), .neg(mneg_reg), .d(den_reg), .done(div_done), .q(div_q)
    );

    logic [AW-1:0] wr_idx, prev_idx;
    assign wr_idx = cnt_reg[AW-1:0];
    assign prev_idx = AW'(cnt_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sr_reg <= sub_re; si_reg <= sub_im;
            dr_reg <= diag_re; di_reg <= diag_im;
            cr_reg <= super_re; ci_reg <= super_im;
            rr_reg <= rhs_re; ri_reg <= rhs_im;
            last_reg <= last_row;
            g_rd_reg <= gamma_mem[AW'(cnt_reg - CW'(1))];
            u_rd_reg <= part_mem[AW'(cnt_reg - CW'(1))];
        end
        else if (cmd.brd)
        begin
            g_rd_reg <= gamma_mem[bidx_reg];
            u_rd_reg <= part_mem[bidx_reg];
        end
        p0_reg <= d_ar * 64'(yr_op);
        p1_reg <= d_ai * 64'(yi_op);
        p2_reg <= d_ar * 64'(yi_op);
        p3_reg <= d_ai * 64'(yr_op);
        if (cmd.mul1)
        begin
            if (stat.first_row)
            begin
                pr_reg <= dr_reg; pi_reg <= di_reg;
            end
            else
            begin
                pr_reg <= zr; pi_reg <= zi;
            end
        end
        if (cmd.mul2)
        begin
            if (stat.first_row)
            begin
                nr_reg <= rr_reg; ni_reg <= ri_reg;
            end
            else
            begin
                nr_reg <= zr; ni_reg <= zi;
            end
        end
        if (cmd.den)
            den_reg <= 64'(umag(pr_reg)) * 64'(umag(pr_reg))
                     + 64'(umag(pi_reg)) * 64'(umag(pi_reg));
        if (cmd.num_y || cmd.num_g)
        begin
            if (n1 == n2)
            begin
                m_reg <= m1 + m2; mneg_reg <= n1;
            end
            else if (m1 >= m2)
            begin
                m_reg <= m1 - m2; mneg_reg <= n1;
            end
            else
            begin
                m_reg <= m2 - m1; mneg_reg <= n2;
            end
        end
        if (cmd.load)
        begin
            yr_reg <= '0; yi_reg <= '0; gr_reg <= '0; gi_reg <= '0;
        end
        if (cmd.cap_yr) yr_reg <= div_q;
        if (cmd.cap_yi) yi_reg <= div_q;
        if (cmd.cap_gr) gr_reg <= div_q;
        if (cmd.cap_gi) gi_reg <= div_q;
        if (cmd.store)
        begin
            part_mem[wr_idx] <= {yi_reg, yr_reg};
            gamma_mem[wr_idx] <= {gi_reg, gr_reg};
        end
        if (cmd.bmul)
        begin
            if (stat.back_first)
            begin
                xr_reg <= u_rd_reg[31:0]; xi_reg <= u_rd_reg[63:32];
            end
            else
            begin
                xr_reg <= zr; xi_reg <= zi;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            sing_reg <= 1'b0;
            ovf_reg <= 1'b0;
            bidx_reg <= '0;
        end
        else
        begin
            if (cmd.load && cnt_reg == CW'(MAX_ROWS))
                ovf_reg <= 1'b1;
            if (cmd.den && stat.singular_now)
                sing_reg <= 1'b1;
            if (cmd.store)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                bidx_reg <= wr_idx;
            end
            else if (cmd.load && last_row && cnt_reg == CW'(MAX_ROWS))
                bidx_reg <= AW'(MAX_ROWS - 1);
            if (cmd.bemit)
                bidx_reg <= bidx_reg - AW'(1);
            if (cmd.run_clear)
            begin
                cnt_reg <= '0;
                sing_reg <= 1'b0;
                ovf_reg <= 1'b0;
            end
        end
    end

    logic [AW-1:0] top_idx;
    assign top_idx = prev_idx;

    assign stat.div_done = div_done;
    assign stat.first_row = (cnt_reg == '0);
    assign stat.full = (cnt_reg == CW'(MAX_ROWS));
    assign stat.last = cmd.load ? last_row : last_reg;
    assign stat.singular_now = (pr_reg == '0) && (pi_reg == '0);
    assign stat.back_first = (bidx_reg == top_idx);
    assign stat.back_zero = (bidx_reg == '0);

    assign sol_re = sing_reg ? '0 : xr_reg;
    assign sol_im = sing_reg ? '0 : xi_reg;
    assign row_index = 6'(bidx_reg);
    assign singular = sing_reg;
    assign too_long = ovf_reg;
    assign end_of_run = (bidx_reg == '0);

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_store_room, clk, rst_n, cmd.store, cnt_reg < CW'(MAX_ROWS))
    `ASSERT_NEXT(a_clear, clk, rst_n, cmd.run_clear, cnt_reg == '0 && !sing_reg)
    `ASSERT_IMPL(a_bemit_room, clk, rst_n, cmd.bemit, bidx_reg != '0)
endmodule

>>> src/ctds_ctrl.sv
// Controller state machine sequencing forward sweep and back substitution.
module ctds_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    output logic            strobe,
    output ctds_pkg::cmd_t  cmd,
    input  ctds_pkg::stat_t stat
);
    import ctds_pkg::*;
    state_t state_reg, state_next;
    logic [1:0] ph_reg, ph_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ph_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg <= ph_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ph_next = ph_reg;
        cmd = '0;
        busy = 1'b1;
        strobe = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    state_next = stat.full ? (stat.last ? ST_BRD : ST_IDLE) : ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                // products for the pivot are registered now; next cycle captures it
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul1 = 1'b1;
                cmd.prod_u = 1'b1;
                state_next = ST_NUM;
            end
            ST_NUM:
            begin
                cmd.mul2 = 1'b1;
                state_next = ST_DEN;
            end
            ST_DEN:
            begin
                cmd.den = 1'b1;
                cmd.num_y = 1'b1;
                ph_next = '0;
                state_next = ST_DIVY;
            end
            ST_DIVY:
            begin
                if (stat.singular_now)
                    state_next = ST_STORE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIVG;
                end
            end
            ST_DIVG:
            begin
                cmd.div_sel_im = ph_reg[0];
                cmd.num_g = ph_reg[1];
                if (stat.div_done)
                begin
                    cmd.cap_yr = (ph_reg == 2'd0);
                    cmd.cap_yi = (ph_reg == 2'd1);
                    cmd.cap_gr = (ph_reg == 2'd2);
                    cmd.cap_gi = (ph_reg == 2'd3);
                    if (ph_reg == 2'd3 || (ph_reg == 2'd1 && stat.last))
                        state_next = ST_STORE;
                    else
                    begin
                        // numerator of the next division is latched with this edge
                        ph_next = ph_reg + 2'd1;
                        cmd.div_sel_im = ph_next[0];
                        cmd.num_g = ph_next[1];
                        cmd.num_y = ~ph_next[1];
                        state_next = ST_DIVY;
                    end
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                state_next = stat.last ? ST_BRD : ST_IDLE;
            end
            ST_BRD:
            begin
                cmd.brd = 1'b1;
                state_next = ST_BWAIT;
            end
            ST_BWAIT:
            begin
                cmd.prod_b = 1'b1;
                state_next = ST_BMUL;
            end
            ST_BMUL:
            begin
                cmd.bmul = 1'b1;
                state_next = ST_BEMIT;
            end
            ST_BEMIT:
            begin
                strobe = 1'b1;
                if (stat.back_zero)
                begin
                    cmd.run_clear = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.bemit = 1'b1;
                    state_next = ST_BRD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `include "assert_macros.svh"
    `ASSERT_IMPL(a_strobe_busy, clk, rst_n, strobe, busy)
    `ASSERT_IMPL(a_store_once, clk, rst_n, cmd.store, !cmd.load)
    `ASSERT_IMPL(a_idle_free, clk, rst_n, state_reg == ST_IDLE, !busy)
endmodule

>>> src/complex_tridiagonal_solver.sv
// Top level of the complex tridiagonal solver.
//  channel | handshake            | payload
//  row in  | start & !busy        | sub/diag/super/rhs re,im, last_row
//  result  | sol_valid, one cycle | sol_re, sol_im, row_index, flags
// A row holds busy through four divisions.
// The last row needs two divisions; a zero pivot skips them.
// A row beyond capacity is dropped in its accept cycle, or starts emission if last.
// Emission gives one beat per BRD/BWAIT/BMUL/BEMIT pass, highest row first.
// Reset clears the run state; the row stores are not cleared.
// The receiver cannot stall; results are strobed once.
module complex_tridiagonal_solver #(
    parameter int MAX_ROWS  = 64,
    parameter int FRAC_BITS = 24
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] sub_re,
    input  logic signed [31:0] sub_im,
    input  logic signed [31:0] diag_re,
    input  logic signed [31:0] diag_im,
    input  logic signed [31:0] super_re,
    input  logic signed [31:0] super_im,
    input  logic signed [31:0] rhs_re,
    input  logic signed [31:0] rhs_im,
    input  logic               last_row,
    output logic               sol_valid,
    output logic signed [31:0] sol_re,
    output logic signed [31:0] sol_im,
    output logic [5:0]         row_index,
    output logic               singular,
    output logic               too_long,
    output logic               end_of_run
);
    import ctds_pkg::*;
    cmd_t  cmd;
    stat_t stat;

    ctds_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .strobe(sol_valid), .cmd(cmd), .stat(stat)
    );

    ctds_datapath #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .sub_re(sub_re), .sub_im(sub_im), .diag_re(diag_re), .diag_im(diag_im),
        .super_re(super_re), .super_im(super_im), .rhs_re(rhs_re), .rhs_im(rhs_im),
        .last_row(last_row), .sol_re(sol_re), .sol_im(sol_im), .row_index(row_index),
        .singular(singular), .too_long(too_long), .end_of_run(end_of_run)
    );
endmodule
